/* hdl/dqd_pkg.sv */
// Shared types and codes for the double-ended queue with delete.
`timescale 1ns / 1ps

package dqd_pkg;

  // Operation codes carried by an input transaction
  typedef enum logic [2:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_POP_BACK   = 3'd1,
    OP_PUSH_FRONT = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_DELETE     = 3'd4
  } op_t;

  // Status codes returned with every result
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // Command broadcast to every cell of the chain
  typedef enum logic [2:0] {
    CM_HOLD        = 3'd0,
    CM_APPEND      = 3'd1,
    CM_SHIFT_BACK  = 3'd2,
    CM_SHIFT_FRONT = 3'd3,
    CM_COMPACT     = 3'd4,
    CM_MATCH       = 3'd5
  } cell_mode_t;

  // Controller states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } fsm_state_t;

  localparam int RESULT_W    = 32;
  localparam int OCCUPANCY_W = 5;
  localparam int OP_W        = 3;

endpackage

/* hdl/dqd_cell.sv */
// One storage cell of the queue chain: holds the entry at a fixed position from the front.
`timescale 1ns / 1ps

module dqd_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int IDX_W      = 4,
  parameter int INDEX      = 0
) (
  input  logic                    clk,
  input  dqd_pkg::cell_mode_t     mode,
  input  logic [IDX_W-1:0]        pos,
  input  logic [DATA_WIDTH-1:0]   word,
  input  logic [DATA_WIDTH-1:0]   prev_data,
  input  logic [DATA_WIDTH-1:0]   next_data,
  output logic [DATA_WIDTH-1:0]   data,
  output logic                    match
);

  localparam logic [IDX_W-1:0] MY_POS = IDX_W'(INDEX);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;
  logic                  match_r;
  logic                  match_nxt;

  // Pick the next content from the broadcast command and the neighbors
  always_comb begin
    data_nxt  = data_r;
    match_nxt = match_r;
    unique case (mode)
      dqd_pkg::CM_APPEND: begin
        if (pos == MY_POS) data_nxt = word;
      end
      dqd_pkg::CM_SHIFT_BACK: begin
        data_nxt = (INDEX == 0) ? word : prev_data;
      end
      dqd_pkg::CM_SHIFT_FRONT: begin
        data_nxt = next_data;
      end
      dqd_pkg::CM_COMPACT: begin
        if (MY_POS >= pos) data_nxt = next_data;
      end
      dqd_pkg::CM_MATCH: begin
        match_nxt = (data_r == word);
      end
      default: begin
      end
    endcase
  end

  // Hold content and match flag
  always_ff @(posedge clk) begin
    data_r  <= data_nxt;
    match_r <= match_nxt;
  end

  assign data  = data_r;
  assign match = match_r;

endmodule

/* hdl/double_ended_queue_with_delete_core.sv */
// Top level of the double-ended queue with delete: controller and chain of cells.
`timescale 1ns / 1ps

// Deque of up to DEPTH words kept in a chain of cells, front entry in cell 0.
// A transaction is taken when start is high and busy is low. For push and pop
// transactions the result strobes on out_valid in the next cycle and busy
// stays low, so one may be issued every cycle. A delete first latches a
// compare flag in every cell, then walks those flags one cell per cycle from
// the front; busy stays high until the walk finds a match or passes the last
// occupied cell, and the result strobes in the same cycle as busy falls. The
// later cells shift one place toward the front in the cycle that finds the
// match. Results show for exactly one cycle and cannot be held off, so the
// receiver must take every strobe. Pops and deletes on an empty deque,
// pushes into a full one and missed deletes leave the contents as they
// were and report it in out_status.
module double_ended_queue_with_delete_core #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [dqd_pkg::OP_W-1:0]           in_operation,
  input  logic [31:0]                        in_value,
  output logic                               out_valid,
  output logic [dqd_pkg::RESULT_W-1:0]       out_result_value,
  output logic [dqd_pkg::OCCUPANCY_W-1:0]    out_occupancy,
  output logic [1:0]                         out_status
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  dqd_pkg::fsm_state_t state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    scan_r, scan_nxt;
  logic [CNT_W-1:0]    cnt_dec;

  dqd_pkg::cell_mode_t mode;
  logic [IDX_W-1:0]    pos;
  logic [DATA_WIDTH-1:0] word;

  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]      cell_match;

  logic                  res_valid;
  logic [dqd_pkg::RESULT_W-1:0] res_value;
  dqd_pkg::status_t      res_status;

  logic                  out_valid_r;
  logic [dqd_pkg::RESULT_W-1:0] out_result_value_r;
  logic [dqd_pkg::OCCUPANCY_W-1:0] out_occupancy_r;
  logic [1:0]            out_status_r;

  assign word    = DATA_WIDTH'(in_value);
  assign cnt_dec = count_r - 1'b1;
  assign busy    = (state_r != dqd_pkg::S_IDLE);

  // Chain of cells, each wired to its neighbors
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [DATA_WIDTH-1:0] prev_d;
    logic [DATA_WIDTH-1:0] next_d;
    if (k == 0) begin : g_first
      assign prev_d = word;
    end else begin : g_mid
      assign prev_d = cell_data[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign next_d = cell_data[k];
    end else begin : g_inner
      assign next_d = cell_data[k+1];
    end
    dqd_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .IDX_W      (IDX_W),
      .INDEX      (k)
    ) u_cell (
      .clk       (clk),
      .mode      (mode),
      .pos       (pos),
      .word      (word),
      .prev_data (prev_d),
      .next_data (next_d),
      .data      (cell_data[k]),
      .match     (cell_match[k])
    );
  end

  // Decode transactions, walk delete flags, form results
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    scan_nxt   = scan_r;
    mode       = dqd_pkg::CM_HOLD;
    pos        = '0;
    res_valid  = 1'b0;
    res_value  = '0;
    res_status = dqd_pkg::ST_OK;
    unique case (state_r)
      dqd_pkg::S_IDLE: begin
        if (start) begin
          res_valid = 1'b1;
          unique case (dqd_pkg::op_t'(in_operation))
            dqd_pkg::OP_PUSH_BACK: begin
              if (count_r == FULL_CNT) begin
                res_status = dqd_pkg::ST_FULL;
              end else begin
                mode      = dqd_pkg::CM_APPEND;
                pos       = count_r[IDX_W-1:0];
                count_nxt = count_r + 1'b1;
              end
            end
            dqd_pkg::OP_PUSH_FRONT: begin
              if (count_r == FULL_CNT) begin
                res_status = dqd_pkg::ST_FULL;
              end else begin
                mode      = dqd_pkg::CM_SHIFT_BACK;
                count_nxt = count_r + 1'b1;
              end
            end
            dqd_pkg::OP_POP_BACK: begin
              if (count_r == '0) begin
                res_status = dqd_pkg::ST_EMPTY;
              end else begin
                res_value = dqd_pkg::RESULT_W'(cell_data[cnt_dec[IDX_W-1:0]]);
                count_nxt = cnt_dec;
              end
            end
            dqd_pkg::OP_POP_FRONT: begin
              if (count_r == '0) begin
                res_status = dqd_pkg::ST_EMPTY;
              end else begin
                res_value = dqd_pkg::RESULT_W'(cell_data[0]);
                mode      = dqd_pkg::CM_SHIFT_FRONT;
                count_nxt = cnt_dec;
              end
            end
            dqd_pkg::OP_DELETE: begin
              if (count_r == '0) begin
                res_status = dqd_pkg::ST_NOT_FOUND;
              end else begin
                res_valid = 1'b0;
                mode      = dqd_pkg::CM_MATCH;
                scan_nxt  = '0;
                state_nxt = dqd_pkg::S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      dqd_pkg::S_SCAN: begin
        priority if (scan_r == count_r) begin
          res_valid  = 1'b1;
          res_status = dqd_pkg::ST_NOT_FOUND;
          state_nxt  = dqd_pkg::S_IDLE;
        end else if (cell_match[scan_r[IDX_W-1:0]]) begin
          res_valid = 1'b1;
          mode      = dqd_pkg::CM_COMPACT;
          pos       = scan_r[IDX_W-1:0];
          count_nxt = cnt_dec;
          state_nxt = dqd_pkg::S_IDLE;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      default: begin
        state_nxt = dqd_pkg::S_IDLE;
      end
    endcase
  end

  // Advance controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dqd_pkg::S_IDLE;
      count_r <= '0;
      scan_r  <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      scan_r  <= scan_nxt;
    end
  end

  // Register the result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_result_value_r <= res_value;
      out_occupancy_r    <= dqd_pkg::OCCUPANCY_W'(count_nxt);
      out_status_r       <= res_status;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_result_value_r;
  assign out_occupancy    = out_occupancy_r;
  assign out_status       = out_status_r;

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for the double-ended queue with delete.
`timescale 1ns / 1ps

module tb_top;

  localparam int DEPTH        = 16;
  localparam int DATA_WIDTH   = 32;
  localparam int RANDOM_ITEMS = 750;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int TAIL_CYCLES  = 2 * DEPTH + 8;
  localparam int MAX_REPORTS  = 10;
  localparam int POOL_SIZE    = 8;

  // One pending command for the driver
  typedef struct {
    logic [dqd_pkg::OP_W-1:0] op;
    logic [31:0]              value;
    bit                       wait_drain;
  } deque_cmd_t;

  // One expected result
  typedef struct {
    logic [dqd_pkg::RESULT_W-1:0]    removed;
    logic [dqd_pkg::OCCUPANCY_W-1:0] occupancy;
    logic [1:0]                      status;
  } deque_result_t;

  logic                            clk          = 1'b0;
  logic                            rst_n        = 1'b0;
  logic                            start        = 1'b0;
  logic                            busy;
  logic [dqd_pkg::OP_W-1:0]        in_operation = '0;
  logic [31:0]                     in_value     = '0;
  logic                            out_valid;
  logic [dqd_pkg::RESULT_W-1:0]    out_result_value;
  logic [dqd_pkg::OCCUPANCY_W-1:0] out_occupancy;
  logic [1:0]                      out_status;

  deque_cmd_t            cmd_queue[$];
  deque_result_t         expected_results[$];
  logic [DATA_WIDTH-1:0] held_words[$];
  logic [31:0]           word_pool[POOL_SIZE];

  int unsigned issued_count   = 0;
  int unsigned accepted_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int          burst_left     = 0;
  int          gap_left       = 0;

  double_ended_queue_with_delete_core #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_result_value (out_result_value),
    .out_occupancy    (out_occupancy),
    .out_status       (out_status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Apply one command to the shadow deque and return what the block should report
  function automatic deque_result_t apply_deque_op(logic [dqd_pkg::OP_W-1:0] op,
                                                   logic [31:0] value);
    deque_result_t         res;
    logic [DATA_WIDTH-1:0] word;
    int                    hit;
    int                    i;
    res.removed = '0;
    res.status  = dqd_pkg::ST_OK;
    word        = value[DATA_WIDTH-1:0];
    hit         = -1;
    case (op)
      dqd_pkg::OP_PUSH_BACK, dqd_pkg::OP_PUSH_FRONT: begin
        if (held_words.size() >= DEPTH) res.status = dqd_pkg::ST_FULL;
        else if (op == dqd_pkg::OP_PUSH_BACK) held_words.push_back(word);
        else held_words.push_front(word);
      end
      dqd_pkg::OP_POP_BACK: begin
        if (held_words.size() == 0) res.status = dqd_pkg::ST_EMPTY;
        else res.removed = dqd_pkg::RESULT_W'(held_words.pop_back());
      end
      dqd_pkg::OP_POP_FRONT: begin
        if (held_words.size() == 0) res.status = dqd_pkg::ST_EMPTY;
        else res.removed = dqd_pkg::RESULT_W'(held_words.pop_front());
      end
      dqd_pkg::OP_DELETE: begin
        for (i = 0; i < held_words.size(); i++) begin
          if (hit < 0 && held_words[i] == word) hit = i;
        end
        if (hit < 0) res.status = dqd_pkg::ST_NOT_FOUND;
        else held_words.delete(hit);
      end
      default: ;
    endcase
    res.occupancy = dqd_pkg::OCCUPANCY_W'(held_words.size());
    return res;
  endfunction

  task automatic report_error(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("%0t ns: %s", $time, msg);
  endtask

  task automatic add_cmd(logic [dqd_pkg::OP_W-1:0] op, logic [31:0] value,
                         bit wait_drain = 1'b0);
    deque_cmd_t cmd;
    cmd.op         = op;
    cmd.value      = value;
    cmd.wait_drain = wait_drain;
    cmd_queue.push_back(cmd);
  endtask

  // Cycle limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  // Monitor: check results first, then record the transaction taken at this edge
  always @(posedge clk) begin
    deque_result_t exp_res;
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        if (expected_results.size() == 0) begin
          report_error($sformatf("unexpected result value %h occupancy %0d status %0d",
                                 out_result_value, out_occupancy, out_status));
        end else begin
          exp_res = expected_results.pop_front();
          if (out_result_value !== exp_res.removed || out_occupancy !== exp_res.occupancy ||
              out_status !== exp_res.status) begin
            report_error($sformatf(
              "mismatch: expected value %h occupancy %0d status %0d, got %h %0d %0d",
              exp_res.removed, exp_res.occupancy, exp_res.status,
              out_result_value, out_occupancy, out_status));
          end
        end
      end
      if (start && !busy) begin
        expected_results.push_back(apply_deque_op(in_operation, in_value));
        accepted_count++;
      end
    end
  end

  // Driver: present commands in bursts, hold each until the block takes it
  always @(negedge clk) begin
    deque_cmd_t next_cmd;
    if (rst_n) begin
      if (start && accepted_count != issued_count) begin
        // hold the transaction until it is taken
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (cmd_queue.size() == 0 ||
                   (cmd_queue[0].wait_drain && expected_results.size() != 0)) begin
        start <= 1'b0;
      end else begin
        next_cmd = cmd_queue.pop_front();
        in_operation <= next_cmd.op;
        in_value     <= next_cmd.value;
        start        <= 1'b1;
        issued_count++;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 90)
                                                   : $urandom_range(1, 20);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int                       k;
    int                       counted;
    int                       phase_left;
    int                       push_bias;
    int                       roll;
    logic [dqd_pkg::OP_W-1:0] op;
    logic [31:0]              value;
    bit                       drain;

    for (k = 0; k < POOL_SIZE; k++) word_pool[k] = $urandom();
    word_pool[0] = 32'h0000_0000;
    word_pool[1] = 32'hFFFF_FFFF;

    // Directed: empty deque corner cases and an unused code
    add_cmd(dqd_pkg::OP_POP_BACK, 32'h0);
    add_cmd(dqd_pkg::OP_POP_FRONT, 32'hFFFF_FFFF);
    add_cmd(dqd_pkg::OP_DELETE, 32'h0);
    add_cmd(dqd_pkg::OP_W'(7), 32'h5A5A_5A5A);
    // Fill from both ends, with a repeated word for delete-first-match
    for (k = 0; k < DEPTH; k++) begin
      if (k == 0) value = 32'h0000_0000;
      else if (k == 1) value = 32'hFFFF_FFFF;
      else if (k % 4 == 3) value = 32'hC0DE_0001;
      else value = 32'(k) * 32'h1111_1111;
      add_cmd((k % 2 == 0) ? dqd_pkg::OP_PUSH_BACK : dqd_pkg::OP_PUSH_FRONT, value);
    end
    // Pushes into a full deque, deletes, pops from both ends
    add_cmd(dqd_pkg::OP_PUSH_BACK, 32'hA5A5_A5A5);
    add_cmd(dqd_pkg::OP_PUSH_FRONT, 32'h5A5A_5A5A);
    add_cmd(dqd_pkg::OP_DELETE, 32'hC0DE_0001);
    add_cmd(dqd_pkg::OP_DELETE, 32'h1357_9BDF);
    add_cmd(dqd_pkg::OP_POP_FRONT, 32'h0);
    add_cmd(dqd_pkg::OP_POP_BACK, 32'h0);

    // Random: phases that lean toward filling or draining
    counted    = 0;
    phase_left = 0;
    push_bias  = 50;
    while (counted < RANDOM_ITEMS) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(20, 80);
        push_bias  = $urandom_range(15, 85);
      end
      phase_left--;
      drain = (counted == 0) || (counted == RANDOM_ITEMS / 2) ||
              ($urandom_range(0, 199) == 0);
      roll  = $urandom_range(0, 99);
      value = $urandom_range(0, 1) ? word_pool[$urandom_range(0, POOL_SIZE - 1)] : $urandom();
      if (roll < 2) begin
        op = dqd_pkg::OP_W'($urandom_range(5, 7));
      end else begin
        counted++;
        if (roll < push_bias) begin
          op = $urandom_range(0, 1) ? dqd_pkg::OP_PUSH_BACK : dqd_pkg::OP_PUSH_FRONT;
        end else begin
          case ($urandom_range(0, 2))
            0:       op = dqd_pkg::OP_POP_BACK;
            1:       op = dqd_pkg::OP_POP_FRONT;
            default: op = dqd_pkg::OP_DELETE;
          endcase
        end
      end
      add_cmd(op, value, drain);
    end

    // Hold reset, then release it on a falling clock edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait for all commands to be taken and all results to arrive
    while (cmd_queue.size() != 0 || accepted_count != issued_count) @(negedge clk);
    while (expected_results.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* double_ended_queue_with_delete_core.f */
hdl/dqd_pkg.sv
hdl/dqd_cell.sv
hdl/double_ended_queue_with_delete_core.sv
dv/tb_top.sv
